>>> rtl/core/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Shared types and constants of the sensor record log.
// ----------------------------------------------------------------------------
package srl_pkg;

    localparam int LOG_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int ID_W  = 16;
    localparam int TS_W  = 32;
    localparam int VAL_W = 32;
    localparam int AVG_W = 40;
    localparam int TOT_W = 11;

    // sum of up to LOG_DEPTH signed values, then scaled by 256 for Q8
    localparam int SUM_W  = VAL_W + ADDR_W;
    localparam int NUM_W  = SUM_W + 8;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam int IN_BITS  = OP_W + ID_W + TS_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ST_W + ID_W + TS_W + 3 * VAL_W + AVG_W + TOT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_STATS  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DIVIDE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] rec_value;
        logic [TS_W-1:0]         rec_time;
        logic [ID_W-1:0]         rec_id;
    } rec_t;

    typedef struct packed {
        op_t                     op;
        logic [ID_W-1:0]         sensor_id;
        logic [TS_W-1:0]         time_stamp;
        logic signed [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        st_t                     status;
        logic [ID_W-1:0]         found_sensor_id;
        logic [TS_W-1:0]         found_timestamp;
        logic signed [VAL_W-1:0] found_value;
        logic signed [VAL_W-1:0] minimum_value;
        logic signed [VAL_W-1:0] maximum_value;
        logic signed [AVG_W-1:0] average_q8;
        logic [TOT_W-1:0]        entry_total;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic append;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic st_we;
        st_t  st_code;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic hit;
        logic scan_end;
        logic div_done;
    } sts_t;

endpackage

>>> rtl/core/srl_ram.sv
// ----------------------------------------------------------------------------
// srl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/srl_dpath.sv
// ----------------------------------------------------------------------------
// srl_dpath
// Record store, running statistics, key scan and Q8 average divider.
// ----------------------------------------------------------------------------
module srl_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  srl_pkg::in_t    in_word,
    input  srl_pkg::cmd_t   cmd,
    output srl_pkg::sts_t   sts,
    output srl_pkg::res_t   res
);

    srl_pkg::in_t                     in_reg;
    logic [srl_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [srl_pkg::VAL_W-1:0] min_reg, min_next;
    logic signed [srl_pkg::VAL_W-1:0] max_reg, max_next;
    logic signed [srl_pkg::SUM_W-1:0] sum_reg, sum_next;

    logic [srl_pkg::CNT_W-1:0]        scan_addr_reg, scan_addr_next;
    logic                             pend_reg, pend_next;
    logic                             issue;
    srl_pkg::rec_t                    rd_rec;
    srl_pkg::rec_t                    wr_rec;
    srl_pkg::rec_t                    found_reg, found_next;
    srl_pkg::st_t                     status_reg, status_next;

    logic [srl_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [srl_pkg::NUM_W-1:0]        quo_reg, quo_next;
    logic                             neg_reg, neg_next;
    logic [srl_pkg::DCNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [srl_pkg::CNT_W:0]          trial;
    logic                             q_bit;
    logic signed [srl_pkg::NUM_W-1:0] scaled;
    logic [srl_pkg::NUM_W-1:0]        quo_signed;

    srl_pkg::res_t                    res_reg, res_next;

    assign issue = scan_addr_reg < count_reg;

    assign wr_rec.rec_value = in_reg.value;
    assign wr_rec.rec_time  = in_reg.time_stamp;
    assign wr_rec.rec_id    = in_reg.sensor_id;

    srl_ram #(
        .WIDTH ($bits(srl_pkg::rec_t)),
        .DEPTH (srl_pkg::LOG_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[srl_pkg::ADDR_W-1:0]),
        .wdata (wr_rec),
        .re    (cmd.scan_step && issue),
        .raddr (scan_addr_reg[srl_pkg::ADDR_W-1:0]),
        .rdata (rd_rec)
    );

    // restoring divide step, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[srl_pkg::NUM_W-1]};
    assign q_bit = trial >= {1'b0, count_reg};
    assign scaled = {sum_reg, 8'd0};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    assign sts.op       = in_reg.op;
    assign sts.full     = count_reg >= srl_pkg::CNT_W'(srl_pkg::LOG_DEPTH);
    assign sts.empty    = count_reg == '0;
    assign sts.hit      = pend_reg && (rd_rec.rec_time == in_reg.time_stamp);
    assign sts.scan_end = !pend_reg && !issue;
    assign sts.div_done = div_cnt_reg == srl_pkg::DCNT_W'(srl_pkg::NUM_W);

    assign res = res_reg;

    always_comb
    begin
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        div_cnt_next   = div_cnt_reg;
        res_next       = res_reg;

        if (cmd.append)
        begin
            count_next = count_reg + 1'b1;
            if (in_reg.value < min_reg)
            begin
                min_next = in_reg.value;
            end
            if (in_reg.value > max_reg)
            begin
                max_next = in_reg.value;
            end
            sum_next = sum_reg + srl_pkg::SUM_W'(in_reg.value);
        end

        if (cmd.scan_start)
        begin
            scan_addr_next = '0;
            pend_next      = 1'b0;
            found_next     = '0;
        end
        else if (cmd.scan_step)
        begin
            if (issue)
            begin
                scan_addr_next = scan_addr_reg + 1'b1;
            end
            pend_next = issue;
            if (sts.hit)
            begin
                found_next = rd_rec;
            end
        end

        if (cmd.div_start)
        begin
            rem_next     = '0;
            neg_next     = scaled[srl_pkg::NUM_W-1];
            quo_next     = scaled[srl_pkg::NUM_W-1] ? (~scaled + 1'b1) : scaled;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next     = q_bit ? srl_pkg::CNT_W'(trial - {1'b0, count_reg})
                                 : trial[srl_pkg::CNT_W-1:0];
            quo_next     = {quo_reg[srl_pkg::NUM_W-2:0], q_bit};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        if (cmd.st_we)
        begin
            status_next = cmd.st_code;
        end

        if (cmd.load_out)
        begin
            res_next             = '0;
            res_next.status      = status_reg;
            res_next.entry_total = srl_pkg::TOT_W'(count_reg);
            case (in_reg.op)
                srl_pkg::OP_LOOKUP:
                begin
                    res_next.found_sensor_id = found_reg.rec_id;
                    res_next.found_timestamp = found_reg.rec_time;
                    res_next.found_value     = found_reg.rec_value;
                end
                srl_pkg::OP_STATS:
                begin
                    if (status_reg == srl_pkg::ST_OK)
                    begin
                        res_next.minimum_value = min_reg;
                        res_next.maximum_value = max_reg;
                        res_next.average_q8    = srl_pkg::AVG_W'($signed(quo_signed));
                    end
                end
                default:
                begin
                    res_next.found_value = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= srl_pkg::INT_MAX;
            max_reg       <= srl_pkg::INT_MIN;
            sum_reg       <= '0;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_word;
        end
        found_reg  <= found_next;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= srl_pkg::CNT_W'(srl_pkg::LOG_DEPTH))
        else $error("record count beyond log depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_addr_reg <= count_reg)
        else $error("scan address past last record");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("running minimum above running maximum");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        div_cnt_reg <= srl_pkg::DCNT_W'(srl_pkg::NUM_W))
        else $error("divider ran past its last step");

endmodule

>>> rtl/core/srl_ctrl.sv
// ----------------------------------------------------------------------------
// srl_ctrl
// Operation sequencer: dispatch, scan, divide and result handoff.
// ----------------------------------------------------------------------------
module srl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  srl_pkg::sts_t  sts,
    output srl_pkg::cmd_t  cmd
);

    srl_pkg::state_t state_reg, state_next;
    logic            valid_reg, valid_next;
    logic            out_free;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign in_ready  = state_reg == srl_pkg::S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srl_pkg::S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg && !out_ready;
        cmd         = '0;
        cmd.st_code = srl_pkg::ST_OK;

        case (state_reg)
            srl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = srl_pkg::S_DISPATCH;
                end
            end
            srl_pkg::S_DISPATCH:
            begin
                cmd.st_we  = 1'b1;
                state_next = srl_pkg::S_FINISH;
                case (sts.op)
                    srl_pkg::OP_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.st_code = srl_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    srl_pkg::OP_LOOKUP:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = srl_pkg::S_SCAN;
                    end
                    srl_pkg::OP_STATS:
                    begin
                        if (sts.empty)
                        begin
                            cmd.st_code = srl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = srl_pkg::S_DIVIDE;
                        end
                    end
                    default:
                    begin
                        cmd.st_code = srl_pkg::ST_OK;
                    end
                endcase
            end
            srl_pkg::S_SCAN:
            begin
                // read of the next record overlaps the compare of the last one
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    cmd.st_we  = 1'b1;
                    state_next = srl_pkg::S_FINISH;
                end
                else if (sts.scan_end)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = srl_pkg::ST_NOT_FOUND;
                    state_next  = srl_pkg::S_FINISH;
                end
            end
            srl_pkg::S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    state_next = srl_pkg::S_FINISH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            srl_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = srl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/sensor_record_log.sv
// ----------------------------------------------------------------------------
// sensor_record_log
// Bounded sensor record log with timestamp lookup and min/max/Q8 average.
// ----------------------------------------------------------------------------
// Usage:
//   One input word per operation on the s_axis channel: append a record,
//   look up the oldest record by timestamp, or report statistics. Each word
//   produces exactly one result word on the m_axis channel.
//   Append, no-op and stats on an empty log go from dispatch straight to
//   the result handoff. Lookup compares one stored record per cycle through
//   the store's single read port, oldest first, and stops at the first match;
//   stats runs the one-bit-per-cycle divider before the result handoff.
//   Operations run one at a time; the next word is accepted once the current
//   result has moved into the output register, so a result may wait there
//   while the following operation runs.
//   Reset empties the log and restores running min/max/sum; the record store
//   itself is not cleared. If m_axis_tready stays low the finished result
//   holds and the next operation waits to hand off its own result.
// ----------------------------------------------------------------------------
module sensor_record_log (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // operation, sensor_id, timestamp, measured_value, zero pad
    input  logic [srl_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status, found_sensor_id, found_timestamp, found_value, minimum_value,
    // maximum_value, average_q8, entry_total, zero pad
    output logic [srl_pkg::OUT_W-1:0]  m_axis_tdata
);

    srl_pkg::in_t  in_word;
    srl_pkg::cmd_t cmd;
    srl_pkg::sts_t sts;
    srl_pkg::res_t res;

    localparam int ID_LO  = srl_pkg::OP_W;
    localparam int TS_LO  = ID_LO + srl_pkg::ID_W;
    localparam int VAL_LO = TS_LO + srl_pkg::TS_W;

    assign in_word.op         = srl_pkg::op_t'(s_axis_tdata[srl_pkg::OP_W-1:0]);
    assign in_word.sensor_id  = s_axis_tdata[ID_LO +: srl_pkg::ID_W];
    assign in_word.time_stamp = s_axis_tdata[TS_LO +: srl_pkg::TS_W];
    assign in_word.value      = s_axis_tdata[VAL_LO +: srl_pkg::VAL_W];

    assign m_axis_tdata = {
        {(srl_pkg::OUT_W - srl_pkg::OUT_BITS){1'b0}},
        res.entry_total,
        res.average_q8,
        res.maximum_value,
        res.minimum_value,
        res.found_value,
        res.found_timestamp,
        res.found_sensor_id,
        res.status
    };

    srl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srl_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word),
        .cmd     (cmd),
        .sts     (sts),
        .res     (res)
    );

endmodule

>>> test/tb_sensor_record_log.sv
// ----------------------------------------------------------------------------
// tb_sensor_record_log
// Self-checking stream testbench for the sensor record log. A queue of
// commands feeds a clocked driver. A clocked monitor predicts each accepted
// word with a behavioral copy of the log and compares every result field.
// Both sides pause at random. One long receiver stall backs up the input.
// Late lookups scan most of the log.
// ----------------------------------------------------------------------------
module tb_sensor_record_log;

    typedef struct {
        srl_pkg::op_t                     op;
        logic [srl_pkg::ID_W-1:0]         sensor_id;
        logic [srl_pkg::TS_W-1:0]         time_stamp;
        logic signed [srl_pkg::VAL_W-1:0] value;
    } log_cmd_t;

    typedef struct {
        srl_pkg::st_t                     status;
        logic [srl_pkg::ID_W-1:0]         found_id;
        logic [srl_pkg::TS_W-1:0]         found_time;
        logic signed [srl_pkg::VAL_W-1:0] found_value;
        logic signed [srl_pkg::VAL_W-1:0] min_value;
        logic signed [srl_pkg::VAL_W-1:0] max_value;
        logic signed [srl_pkg::AVG_W-1:0] avg_q8;
        logic [srl_pkg::TOT_W-1:0]        total;
    } log_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [srl_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [srl_pkg::OUT_W-1:0] m_axis_tdata;

    // commands not yet offered, and results predicted but not yet seen
    log_cmd_t    pending_cmds[$];
    log_result_t expected_results[$];
    log_cmd_t    cur_cmd;

    // behavioral copy of the log
    logic [srl_pkg::ID_W-1:0]         rec_id[srl_pkg::LOG_DEPTH];
    logic [srl_pkg::TS_W-1:0]         rec_time[srl_pkg::LOG_DEPTH];
    logic signed [srl_pkg::VAL_W-1:0] rec_value[srl_pkg::LOG_DEPTH];
    int                               rec_count = 0;
    logic signed [srl_pkg::VAL_W-1:0] low_water = srl_pkg::INT_MAX;
    logic signed [srl_pkg::VAL_W-1:0] high_water = srl_pkg::INT_MIN;
    longint                           value_sum = 0;

    // generator's own view of what has been appended
    logic [srl_pkg::TS_W-1:0] gen_times[$];
    int                       gen_count = 0;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic hold_off = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   sent_count = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   total_items = 0;

    sensor_record_log i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic log_result_t log_apply(input log_cmd_t c);
        log_result_t r;
        longint      scaled;
        r = '{srl_pkg::ST_OK, '0, '0, '0, '0, '0, '0, '0};
        case (c.op)
            srl_pkg::OP_APPEND:
            begin
                if (rec_count >= srl_pkg::LOG_DEPTH)
                    r.status = srl_pkg::ST_FULL;
                else
                begin
                    rec_id[rec_count]    = c.sensor_id;
                    rec_time[rec_count]  = c.time_stamp;
                    rec_value[rec_count] = c.value;
                    rec_count++;
                    if (c.value < low_water)
                        low_water = c.value;
                    if (c.value > high_water)
                        high_water = c.value;
                    value_sum += longint'(c.value);
                end
            end
            srl_pkg::OP_LOOKUP:
            begin
                r.status = srl_pkg::ST_NOT_FOUND;
                // oldest match wins
                for (int k = 0; k < rec_count; k++)
                begin
                    if (rec_time[k] == c.time_stamp)
                    begin
                        r.status      = srl_pkg::ST_OK;
                        r.found_id    = rec_id[k];
                        r.found_time  = rec_time[k];
                        r.found_value = rec_value[k];
                        break;
                    end
                end
            end
            srl_pkg::OP_STATS:
            begin
                if (rec_count == 0)
                    r.status = srl_pkg::ST_EMPTY;
                else
                begin
                    scaled      = (value_sum * 256) / longint'(rec_count);
                    r.min_value = low_water;
                    r.max_value = high_water;
                    r.avg_q8    = scaled[srl_pkg::AVG_W-1:0];
                end
            end
            default: ;
        endcase
        r.total = rec_count[srl_pkg::TOT_W-1:0];
        return r;
    endfunction

    function automatic logic [srl_pkg::IN_W-1:0] pack_cmd(input log_cmd_t c);
        logic [srl_pkg::IN_W-1:0] w;
        w = '0;
        w[0 +: srl_pkg::OP_W]                                 = c.op;
        w[srl_pkg::OP_W +: srl_pkg::ID_W]                     = c.sensor_id;
        w[srl_pkg::OP_W + srl_pkg::ID_W +: srl_pkg::TS_W]     = c.time_stamp;
        w[srl_pkg::OP_W + srl_pkg::ID_W + srl_pkg::TS_W +: srl_pkg::VAL_W] = c.value;
        return w;
    endfunction

    // every fourth block of 40 words runs back to back
    function automatic int draw_wait(input int n);
        return ((n / 40) % 4 == 3) ? 0 : int'($urandom_range(0, 9));
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_cmd(input srl_pkg::op_t op, input logic [srl_pkg::ID_W-1:0] sid,
                            input logic [srl_pkg::TS_W-1:0] ts,
                            input logic signed [srl_pkg::VAL_W-1:0] val);
        log_cmd_t c;
        c = '{op, sid, ts, val};
        if (op == srl_pkg::OP_APPEND && gen_count < srl_pkg::LOG_DEPTH)
        begin
            gen_times.push_back(ts);
            gen_count++;
        end
        pending_cmds.push_back(c);
    endtask

    function automatic logic signed [srl_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return srl_pkg::INT_MIN;
            1:       return srl_pkg::INT_MAX;
            2, 3:    return srl_pkg::VAL_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [srl_pkg::TS_W-1:0] pick_time();
        return ($urandom_range(0, 1) == 0) ? srl_pkg::TS_W'($urandom_range(0, 63))
                                           : $urandom();
    endfunction

    // mostly keys that are in the log, else likely misses
    function automatic logic [srl_pkg::TS_W-1:0] pick_key();
        if (gen_times.size() > 0 && $urandom_range(0, 3) != 0)
            return gen_times[$urandom_range(0, gen_times.size() - 1)];
        return pick_time();
    endfunction

    task automatic push_random(input int append_pct, input int lookup_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < append_pct)
            push_cmd(srl_pkg::OP_APPEND, srl_pkg::ID_W'($urandom()), pick_time(),
                     pick_value());
        else if (roll < append_pct + lookup_pct)
            push_cmd(srl_pkg::OP_LOOKUP, srl_pkg::ID_W'($urandom()), pick_key(),
                     $urandom());
        else if (roll < 96)
            push_cmd(srl_pkg::OP_STATS, srl_pkg::ID_W'($urandom()), $urandom(),
                     $urandom());
        else
            push_cmd(srl_pkg::OP_NONE, srl_pkg::ID_W'($urandom()), $urandom(),
                     $urandom());
    endtask

    // driver
    always @(negedge clk)
    begin
        log_cmd_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_wait     <= 0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (send_wait > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait     <= send_wait - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                cur_cmd       <= c;
                s_axis_tdata  <= pack_cmd(c);
                s_axis_tvalid <= 1'b1;
                send_wait     <= draw_wait(sent_count);
                sent_count    <= sent_count + 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        int w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
        end
        else
        begin
            w = out_fire ? draw_wait(results_seen) : recv_wait;
            if (hold_off || w > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_wait     <= (w > 0) ? w - 1 : 0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_wait     <= 0;
            end
        end
    end

    // monitor: predict on input accept, compare on output accept
    always @(posedge clk)
    begin
        log_result_t want;
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            in_fire  <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(log_apply(cur_cmd));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result word with nothing expected: %h",
                                 $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status),
                                64'(m_axis_tdata[0 +: srl_pkg::ST_W]));
                    check_field("found_sensor_id", 64'(want.found_id),
                                64'(m_axis_tdata[2 +: srl_pkg::ID_W]));
                    check_field("found_timestamp", 64'(want.found_time),
                                64'(m_axis_tdata[18 +: srl_pkg::TS_W]));
                    check_field("found_value", 64'($unsigned(want.found_value)),
                                64'(m_axis_tdata[50 +: srl_pkg::VAL_W]));
                    check_field("minimum_value", 64'($unsigned(want.min_value)),
                                64'(m_axis_tdata[82 +: srl_pkg::VAL_W]));
                    check_field("maximum_value", 64'($unsigned(want.max_value)),
                                64'(m_axis_tdata[114 +: srl_pkg::VAL_W]));
                    check_field("average_q8", 64'($unsigned(want.avg_q8)),
                                64'(m_axis_tdata[146 +: srl_pkg::AVG_W]));
                    check_field("entry_total", 64'(want.total),
                                64'(m_axis_tdata[186 +: srl_pkg::TOT_W]));
                end
            end
        end
    end

    // one long receiver stall so the block backs up into its input
    initial
    begin
        while (results_seen < 50)
            @(negedge clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #18_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        // empty log, no-op, extremes, duplicate keys
        push_cmd(srl_pkg::OP_STATS, 16'h0, 32'h0, 32'sh0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'hFFFF, 32'h0, srl_pkg::INT_MIN);
        push_cmd(srl_pkg::OP_NONE, 16'hA5A5, 32'h1234_5678, -32'sd5);
        push_cmd(srl_pkg::OP_APPEND, 16'h0000, 32'h0000_0000, srl_pkg::INT_MIN);
        push_cmd(srl_pkg::OP_STATS, 16'h0, 32'h0, 32'sh0);
        push_cmd(srl_pkg::OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF, srl_pkg::INT_MAX);
        push_cmd(srl_pkg::OP_APPEND, 16'h1234, 32'h0000_0000, -32'sd1);
        push_cmd(srl_pkg::OP_APPEND, 16'h00FF, 32'd100, 32'sd0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, 32'h0000_0000, 32'sh0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, 32'hFFFF_FFFF, 32'sh0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, 32'd100, 32'sh0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, 32'd12345, 32'sh0);
        push_cmd(srl_pkg::OP_STATS, 16'hFFFF, 32'hFFFF_FFFF, srl_pkg::INT_MIN);
        push_cmd(srl_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, -32'sd1);
        push_cmd(srl_pkg::OP_APPEND, 16'h0042, 32'd7, -32'sd3);
        push_cmd(srl_pkg::OP_APPEND, 16'h0043, 32'd7, 32'sd2);
        push_cmd(srl_pkg::OP_STATS, 16'h0, 32'h0, 32'sh0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, 32'd7, 32'sh0);

        // mixed traffic, the log grows to a few hundred records
        repeat (540)
            push_random(50, 30);

        // newest key and a likely miss: scans over most or all of the log
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, gen_times[gen_times.size() - 1], 32'sh0);
        push_cmd(srl_pkg::OP_LOOKUP, 16'h0, 32'hDEAD_BEEF, 32'sh0);
        push_cmd(srl_pkg::OP_STATS, 16'h0, 32'h0, 32'sh0);
        repeat (18)
            push_random(30, 50);
        total_items = pending_cmds.size();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (results_seen < total_items)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
